// File: rtl/tcq_pkg.sv
// tcq_pkg: shared types and codes for the two-class queue with selective dequeue
// no dependencies; imported by the interfaces, the entry store and the top level

package tcq_pkg;

    localparam int TAG_W = 16;

    // request codes
    typedef enum logic [1:0] {
        CMD_ENQ     = 2'd0,
        CMD_DEQ_ANY = 2'd1,
        CMD_DEQ_K0  = 2'd2,
        CMD_DEQ_K1  = 2'd3
    } t_cmd;

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NONE = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // one stored entry: class bit above the tag
    typedef struct packed {
        logic             kind;
        logic [TAG_W-1:0] tag;
    } t_entry;

    // sequencer states, one-hot
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

endpackage

// File: rtl/tcq_if.sv
// tcq_req_if / tcq_rsp_if: valid/ready channels for requests and results
// depends on tcq_pkg for the tag width

interface tcq_req_if;
    import tcq_pkg::*;
    logic             valid;
    logic             ready;
    logic [1:0]       cmd;
    logic             kind;
    logic [TAG_W-1:0] tag;

    modport source (output valid, output cmd, output kind, output tag, input ready);
    modport sink   (input valid, input cmd, input kind, input tag, output ready);
endinterface

interface tcq_rsp_if #(
    parameter int OCC_W = 5
);
    import tcq_pkg::*;
    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic             out_kind;
    logic [TAG_W-1:0] out_tag;
    logic [OCC_W-1:0] occupancy;

    modport source (output valid, output status, output out_kind, output out_tag,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input out_kind, input out_tag,
                    input occupancy, output ready);
endinterface

// File: rtl/tcq_store.sv
// tcq_store: entry memory, one write port and one registered read port
// depends on tcq_pkg for the entry type

module tcq_store #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic            i_clk,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  tcq_pkg::t_entry i_wr_data,
    input  logic [AW-1:0]   i_rd_addr,
    output tcq_pkg::t_entry o_rd_data
);
    import tcq_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/two_class_fifo_selective_dequeue_top.sv
// two_class_fifo_selective_dequeue_top: bounded two-class queue with selective dequeue
// depends on tcq_pkg, tcq_req_if / tcq_rsp_if and tcq_store
//
// usage
//   i_req carries one request beat: cmd (enqueue, dequeue oldest, dequeue oldest of
//   class 0 or class 1), plus kind and tag for enqueues. o_rsp returns exactly one
//   result beat per request: status, removed class and tag, and the occupancy after
//   the request. o_rsp must be built with OCC_W = $clog2(CAPACITY + 1)
//   sequencing
//   one request at a time; i_req.ready is high only while the sequencer is idle
//   enqueue, full or empty cases: the accept moves the sequencer straight to the done
//   state, which loads the result register once it is free and returns to idle
//   selective dequeue: the single memory read port walks the entries oldest first,
//   one per cycle, then the same port copies each younger entry down one slot;
//   a hit goes from the scan state through the shift state to the done state; a
//   miss goes from the scan state straight to the done state after the last entry
//   reset
//   synchronous, active low; the occupancy count and control clear, the memory is
//   left as is (only slots below the count are ever used), no clearing pass
//   stalls
//   a result waits in the output register while o_rsp.ready is low; the next
//   request is still accepted and worked on, and holds in the done state until
//   the output register frees

module two_class_fifo_selective_dequeue_top #(
    parameter int CAPACITY = 16,
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    tcq_req_if.sink  i_req,
    tcq_rsp_if.source o_rsp
);
    import tcq_pkg::*;

    // sequencer and request latch
    t_state           r_state, n_state;
    logic [1:0]       r_cmd, n_cmd;

    // queue bookkeeping
    logic [CW-1:0]    r_count, n_count;
    logic [AW-1:0]    r_idx, n_idx;

    // result being built
    logic [1:0]       r_status, n_status;
    logic             r_okind, n_okind;
    logic [TAG_W-1:0] r_otag, n_otag;

    // output register
    logic             r_rsp_valid;
    logic [1:0]       r_rsp_status;
    logic             r_rsp_kind;
    logic [TAG_W-1:0] r_rsp_tag;
    logic [CW-1:0]    r_rsp_occ;

    // memory port
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    t_entry           wr_data;
    logic [AW-1:0]    rd_addr;
    t_entry           rd_data;

    logic             req_fire;
    logic             rsp_load;
    logic             hit;
    logic             want_kind;
    logic [CW-1:0]    idx_next;

    tcq_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign req_fire    = i_req.valid && i_req.ready;

    // the done state hands over as soon as the output register is free
    assign rsp_load = (r_state == S_DONE) && (!r_rsp_valid || o_rsp.ready);

    // class wanted by a class-specific dequeue; dequeue-any takes whatever is oldest
    assign want_kind = (r_cmd == CMD_DEQ_K1);
    assign hit       = (r_cmd == CMD_DEQ_ANY) || (rd_data.kind == want_kind);
    assign idx_next  = CW'(r_idx) + CW'(1);

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_count  = r_count;
        n_idx    = r_idx;
        n_status = r_status;
        n_okind  = r_okind;
        n_otag   = r_otag;
        wr_en    = 1'b0;
        wr_addr  = r_idx;
        wr_data  = rd_data;
        rd_addr  = r_idx;

        unique case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    n_cmd    = i_req.cmd;
                    n_status = ST_OK;
                    n_okind  = 1'b0;
                    n_otag   = '0;
                    if (i_req.cmd == CMD_ENQ) begin
                        // append at the tail, or refuse when full
                        if (r_count == CW'(CAPACITY)) begin
                            n_status = ST_FULL;
                        end else begin
                            wr_en        = 1'b1;
                            wr_addr      = r_count[AW-1:0];
                            wr_data.kind = i_req.kind;
                            wr_data.tag  = i_req.tag;
                            n_count      = r_count + CW'(1);
                        end
                        n_state = S_DONE;
                    end else if (r_count == '0) begin
                        n_status = ST_NONE;
                        n_state  = S_DONE;
                    end else begin
                        // start the scan at the oldest slot
                        n_idx   = '0;
                        rd_addr = '0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // rd_data holds slot r_idx
                if (hit) begin
                    n_okind = rd_data.kind;
                    n_otag  = rd_data.tag;
                    rd_addr = r_idx + AW'(1);
                    n_state = S_SHIFT;
                end else if (idx_next >= r_count) begin
                    n_status = ST_NONE;
                    n_state  = S_DONE;
                end else begin
                    n_idx   = r_idx + AW'(1);
                    rd_addr = r_idx + AW'(1);
                end
            end
            S_SHIFT: begin
                // rd_data holds slot r_idx + 1; move it down to close the gap
                if (idx_next < r_count) begin
                    wr_en   = 1'b1;
                    wr_addr = r_idx;
                    wr_data = rd_data;
                    n_idx   = r_idx + AW'(1);
                    rd_addr = r_idx + AW'(2);
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (rsp_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (rsp_load) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_idx    <= n_idx;
        r_status <= n_status;
        r_okind  <= n_okind;
        r_otag   <= n_otag;
        if (rsp_load) begin
            r_rsp_status <= r_status;
            r_rsp_kind   <= r_okind;
            r_rsp_tag    <= r_otag;
            r_rsp_occ    <= r_count;
        end
    end

    assign o_rsp.valid     = r_rsp_valid;
    assign o_rsp.status    = r_rsp_status;
    assign o_rsp.out_kind  = r_rsp_kind;
    assign o_rsp.out_tag   = r_rsp_tag;
    assign o_rsp.occupancy = r_rsp_occ;

endmodule

// File: rtl/tcq_checker.sv
// tcq_checker: port-level assertions for the two-class queue, plus its bind
// depends on tcq_pkg and on the ports of two_class_fifo_selective_dequeue_top

module tcq_checker #(
    parameter int CAPACITY = 16,
    parameter int CW       = 5
) (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_rsp_valid,
    input logic                      i_rsp_ready,
    input logic [1:0]                i_status,
    input logic                      i_out_kind,
    input logic [tcq_pkg::TAG_W-1:0] i_out_tag,
    input logic [CW-1:0]             i_occupancy
);
    import tcq_pkg::*;

    // occupancy never above capacity
    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_occupancy <= CW'(CAPACITY)))
        else $error("occupancy above capacity");

    // a full refusal only when the queue really is full
    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && (i_status == ST_FULL)) |-> (i_occupancy == CW'(CAPACITY)))
        else $error("full status with room left");

    // a failed request, which removes nothing, reports zero class and tag
    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && (i_status != ST_OK)) |-> ((i_out_kind == 1'b0) && (i_out_tag == '0)))
        else $error("non-zero payload on failed request");

    // a stalled result beat stays valid and holds its status, tag and occupancy
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_status) && $stable(i_out_tag) && $stable(i_occupancy)))
        else $error("result beat changed while stalled");

endmodule

bind two_class_fifo_selective_dequeue_top tcq_checker #(
    .CAPACITY (CAPACITY),
    .CW       (CW)
) u_tcq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_status    (o_rsp.status),
    .i_out_kind  (o_rsp.out_kind),
    .i_out_tag   (o_rsp.out_tag),
    .i_occupancy (o_rsp.occupancy)
);

// File: tb/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for the two-class queue with selective dequeue
// depends on tcq_pkg, tcq_req_if / tcq_rsp_if and two_class_fifo_selective_dequeue_top

module testbench;
    import tcq_pkg::*;

    localparam int DEPTH      = 16;
    localparam int OCC_BITS   = 5;
    localparam int RAND_ITEMS = 1000;
    localparam int HOLD_AT    = 700;     // results seen before the long receiver hold
    localparam int HOLD_LEN   = 300;     // cycles of that hold
    localparam int DRAIN_MAX  = 20000;   // limit on waiting for the last results

    // one result beat as the bench predicts and sees it
    typedef struct packed {
        logic [1:0]          status;
        logic                kind;
        logic [TAG_W-1:0]    tag;
        logic [OCC_BITS-1:0] occ;
    } t_result;

    // shadow copy of the queue contents plus the results still owed by the block
    class two_class_tracker;
        t_entry  held[$];
        t_result owed[$];
        int      errors;

        function new();
            errors = 0;
        endfunction

        // work out the result of an accepted request and update the shadow queue
        function void note_request(t_cmd c, logic k, logic [TAG_W-1:0] t);
            t_result r;
            t_entry  e;
            int      pos;
            int      i;
            r   = '0;
            pos = -1;
            if (c == CMD_ENQ) begin
                if (held.size() >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    e.kind = k;
                    e.tag  = t;
                    held   = {held, e};
                    r.status = ST_OK;
                end
            end else begin
                i = 0;
                while (pos < 0 && i < held.size()) begin
                    if (c == CMD_DEQ_ANY || held[i].kind == (c == CMD_DEQ_K1))
                        pos = i;
                    i++;
                end
                if (pos < 0) begin
                    r.status = ST_NONE;
                end else begin
                    r.status = ST_OK;
                    r.kind   = held[pos].kind;
                    r.tag    = held[pos].tag;
                    held.delete(pos);
                end
            end
            r.occ = OCC_BITS'(held.size());
            owed  = {owed, r};
        endfunction

        // compare one result beat against the oldest one owed
        function void check_result(t_result got);
            t_result want;
            if (owed.size() == 0) begin
                if (errors < 10)
                    $display("%0t: result with no request pending: st=%0d k=%0d tag=%h occ=%0d",
                             $time, got.status, got.kind, got.tag, got.occ);
                errors++;
            end else begin
                want = owed.pop_front();
                if (got !== want) begin
                    if (errors < 10)
                        $display({"%0t: mismatch exp st=%0d k=%0d tag=%h occ=%0d,",
                                  " got st=%0d k=%0d tag=%h occ=%0d"},
                                 $time, want.status, want.kind, want.tag, want.occ,
                                 got.status, got.kind, got.tag, got.occ);
                    errors++;
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    tcq_req_if                       req_if ();
    tcq_rsp_if #(.OCC_W(OCC_BITS))   rsp_if ();

    two_class_fifo_selective_dequeue_top #(
        .CAPACITY (DEPTH)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    two_class_tracker board;
    int               idle_pct;       // chance in a hundred that either side idles a cycle
    int               results_seen;

    // 100 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    // offer one request beat, with random gaps before it, and wait for its accept;
    // inputs are sampled at the edge before the block's own updates land
    task automatic send_request(input t_cmd c, input logic k, input logic [TAG_W-1:0] t);
        while ($urandom_range(99) < idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.cmd   <= c;
        req_if.kind  <= k;
        req_if.tag   <= t;
        do
            @(posedge i_clk);
        while (!req_if.ready);
        board.note_request(c, k, t);
    endtask

    // random dequeue flavour; kind and tag carry noise the block must ignore
    task automatic send_dequeue();
        t_cmd c;
        case ($urandom_range(2))
            0:       c = CMD_DEQ_ANY;
            1:       c = CMD_DEQ_K0;
            default: c = CMD_DEQ_K1;
        endcase
        send_request(c, 1'($urandom_range(1)), 16'($urandom_range(16'hffff)));
    endtask

    // result side: check every accepted beat, toggle ready at random, and once
    // hold ready low for a long stretch so the block backs up into its input
    initial begin
        int hold_left;
        bit held_off;
        t_result got;
        hold_left       = 0;
        held_off        = 1'b0;
        results_seen    = 0;
        rsp_if.ready   <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_if.valid && rsp_if.ready) begin
                got.status = rsp_if.status;
                got.kind   = rsp_if.out_kind;
                got.tag    = rsp_if.out_tag;
                got.occ    = rsp_if.occupancy;
                board.check_result(got);
                results_seen++;
            end
            if (!held_off && results_seen >= HOLD_AT) begin
                held_off  = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    // request side and end of run
    initial begin
        int   n;
        int   i;
        int   enq_pct;
        int   drain;
        logic k;
        board         = new();
        idle_pct      = 27;
        enq_pct       = 50;
        i_rst_n      <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.cmd   <= CMD_ENQ;
        req_if.kind  <= 1'b0;
        req_if.tag   <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty queue: every dequeue flavour finds nothing
        send_request(CMD_DEQ_ANY, 1'b1, 16'hffff);
        send_request(CMD_DEQ_K0,  1'b1, 16'hffff);
        send_request(CMD_DEQ_K1,  1'b0, 16'h0000);
        // one class 0 entry: asking for class 1 finds nothing, class 0 takes it
        send_request(CMD_ENQ,     1'b0, 16'h0000);
        send_request(CMD_DEQ_K1,  1'b0, 16'h1234);
        send_request(CMD_DEQ_K0,  1'b1, 16'hffff);
        // fill to capacity with both classes and extreme tags
        for (i = 0; i < DEPTH; i++) begin
            k = (i % 3 == 1);
            case (i % 4)
                0:       send_request(CMD_ENQ, k, 16'h0000);
                1:       send_request(CMD_ENQ, k, 16'hffff);
                2:       send_request(CMD_ENQ, k, 16'h5555);
                default: send_request(CMD_ENQ, k, 16'haaaa);
            endcase
        end
        // full: nothing stored
        send_request(CMD_ENQ,     1'b1, 16'hffff);
        // a class 1 removal from the middle closes the gap, then oldest of class 0, of any
        send_request(CMD_DEQ_K1,  1'b0, 16'h0000);
        send_request(CMD_DEQ_K0,  1'b1, 16'hffff);
        send_request(CMD_DEQ_ANY, 1'b0, 16'h0000);

        // random part: the enqueue bias is drawn anew every fifty beats so the queue
        // swings between empty and full; one window runs with no idling at all
        for (n = 0; n < RAND_ITEMS; n++) begin
            if (n % 50 == 0) begin
                case ($urandom_range(2))
                    0:       enq_pct = 20;
                    1:       enq_pct = 50;
                    default: enq_pct = 80;
                endcase
            end
            idle_pct = (n >= 300 && n < 550) ? 0 : 27;
            if ($urandom_range(99) < enq_pct)
                send_request(CMD_ENQ, 1'($urandom_range(1)), 16'($urandom_range(16'hffff)));
            else
                send_dequeue();
        end
        req_if.valid <= 1'b0;

        // wait for every owed result, then a margin for anything stray
        drain = 0;
        while (board.owed.size() != 0 && drain < DRAIN_MAX) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (2 * DEPTH + 4) @(posedge i_clk);
        if (board.owed.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, board.owed.size());
            board.errors += board.owed.size();
        end

        if (board.errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

// File: sim.f
rtl/tcq_pkg.sv
rtl/tcq_if.sv
rtl/tcq_store.sv
rtl/two_class_fifo_selective_dequeue_top.sv
rtl/tcq_checker.sv
tb/testbench.sv
